// File: sv/spcc_pkg.sv
// package for the sector page cache controller
// types, constants and command/status structs shared by controller and datapath
package spcc_pkg;

	localparam int SlotCount = 16;
	localparam int SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
	localparam int SlotCntW = $clog2(SlotCount + 1);
	localparam int Sectors = 8;
	localparam int PageW = 45;
	localparam int AddrW = 48;
	localparam logic [7:0] FullMask = 8'hFF;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_GRANT = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_WB,
		ST_PREAD,
		ST_GRANT,
		ST_BAD
	} state_t;

	typedef struct packed {
		logic load;      // capture request, bump counter
		logic scan_init;
		logic scan_step;
		logic wb_init;
		logic wb_step;   // advance dirty walk one position
		logic emit;      // drive output register
		kind_t emit_kind;
		logic upd_pread; // install page after read
		logic upd_write; // apply write mask
		logic upd_stamp;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic scan_done;
		logic hit;
		logic wr;
		logic full;
		logic wb_done;
		logic run_ready; // a run ends at the current walk position
		logic out_busy;
	} sts_t;

endpackage

// File: sv/spcc_ctrl.sv
// controller state machine of the sector page cache controller
// depends on spcc_pkg
module spcc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  spcc_pkg::sts_t sts,
	output spcc_pkg::cmd_t cmd
);
	import spcc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.emit_kind = KIND_GRANT;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.bad) begin
					state_d = ST_BAD;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					cmd.scan_step = 1'b0;
					if (sts.wr) begin
						if (sts.hit) begin
							state_d = ST_GRANT;
						end else begin
							cmd.wb_init = 1'b1;
							state_d = ST_WB;
						end
					end else if (sts.hit && sts.full) begin
						state_d = ST_GRANT;
					end else begin
						cmd.wb_init = 1'b1;
						state_d = ST_WB;
					end
				end
			end
			ST_WB: begin
				if (sts.wb_done) begin
					state_d = sts.wr ? ST_GRANT : ST_PREAD;
				end else if (sts.run_ready) begin
					if (!sts.out_busy) begin
						cmd.emit = 1'b1;
						cmd.emit_kind = KIND_WRITE;
						cmd.wb_step = 1'b1;
					end
				end else begin
					cmd.wb_step = 1'b1;
				end
			end
			ST_PREAD: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_READ;
					cmd.upd_pread = 1'b1;
					state_d = ST_GRANT;
				end
			end
			ST_GRANT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_GRANT;
					cmd.upd_write = sts.wr;
					cmd.upd_stamp = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_BAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: sv/spcc_dp.sv
// datapath of the sector page cache controller: slot tables, scan, dirty walk
// and output register; depends on spcc_pkg
module spcc_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic [51:0] in_data,
	input  logic in_func,
	input  spcc_pkg::cmd_t cmd,
	output spcc_pkg::sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] out_data,
	output logic [1:0] out_kind,
	output logic out_last
);
	import spcc_pkg::*;

	logic [PageW-1:0] page_q [SlotCount];
	logic [7:0]       vmask_q [SlotCount];
	logic [7:0]       dmask_q [SlotCount];
	logic [31:0]      stamp_q [SlotCount];
	logic [31:0]      counter_q;

	logic [AddrW-1:0] addr_q;
	logic [3:0]       count_q;
	logic             wr_q;
	logic [SlotCntW-1:0] scan_q;
	logic             hit_q;
	logic [SlotW-1:0] sel_q;
	logic [SlotW-1:0] vic_q;
	logic [31:0]      vic_stamp_q;
	logic [3:0]       pos_q;
	logic [3:0]       head_q;

	logic             ovalid_q;
	logic [1:0]       okind_q;
	logic [47:0]      osec_q;
	logic [3:0]       olen_q;
	logic [3:0]       oslot_q;
	logic [2:0]       ooff_q;
	logic             ohit_q;
	logic             olast_q;

	logic [2:0]       off;
	logic [PageW-1:0] page;
	logic [4:0]       span;
	logic [SlotW-1:0] cur;
	logic [SlotW-1:0] slot;
	logic             set_bit;
	logic [7:0]       wmask;

	assign off = addr_q[2:0];
	assign page = addr_q[AddrW-1:3];
	assign span = {2'b0, off} + {1'b0, count_q};
	assign cur = scan_q[SlotW-1:0];
	assign slot = hit_q ? sel_q : vic_q;
	assign set_bit = (pos_q < 4'd8) && dmask_q[slot][pos_q[2:0]];
	assign wmask = 8'((9'd1 << count_q) - 9'd1) << off;

	always_comb begin
		sts = '0;
		sts.bad = (count_q == 4'd0) || (span > 5'd8);
		sts.scan_done = hit_q || (scan_q == SlotCntW'(SlotCount));
		sts.hit = hit_q;
		sts.wr = wr_q;
		sts.full = vmask_q[sel_q] == FullMask;
		sts.wb_done = pos_q > 4'd8;
		sts.run_ready = !set_bit && (head_q != pos_q);
		sts.out_busy = ovalid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SlotCount; i++) begin
				page_q[i] <= '0;
				vmask_q[i] <= '0;
				dmask_q[i] <= '0;
				stamp_q[i] <= '0;
			end
			counter_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				counter_q <= counter_q + 32'd1;
			end
			// dirty run walk clears the slot once past the end
			if (cmd.wb_step && pos_q == 4'd8) begin
				dmask_q[slot] <= '0;
				vmask_q[slot] <= '0;
			end
			if (cmd.upd_pread) begin
				page_q[slot] <= page;
				vmask_q[slot] <= FullMask;
				dmask_q[slot] <= '0;
			end
			if (cmd.upd_write) begin
				if (!hit_q) begin
					page_q[slot] <= page;
				end
				dmask_q[slot] <= dmask_q[slot] | wmask;
				vmask_q[slot] <= vmask_q[slot] | dmask_q[slot] | wmask;
			end
			if (cmd.upd_stamp) begin
				stamp_q[slot] <= counter_q;
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= in_data[47:0];
			count_q <= in_data[51:48];
			wr_q <= in_func;
		end
		if (cmd.scan_init) begin
			scan_q <= '0;
			hit_q <= 1'b0;
			vic_q <= '0;
			vic_stamp_q <= stamp_q[0];
			sel_q <= '0;
		end
		if (cmd.scan_step) begin
			scan_q <= scan_q + SlotCntW'(1);
			if (vmask_q[cur] != 8'd0 && page_q[cur] == page) begin
				hit_q <= 1'b1;
				sel_q <= cur;
			end
			if (stamp_q[cur] < vic_stamp_q) begin
				vic_q <= cur;
				vic_stamp_q <= stamp_q[cur];
			end
		end
		if (cmd.wb_init) begin
			pos_q <= '0;
			head_q <= '0;
		end
		if (cmd.wb_step) begin
			pos_q <= pos_q + 4'd1;
			if (!set_bit) begin
				head_q <= pos_q + 4'd1;
			end
		end
		if (cmd.emit) begin
			okind_q <= cmd.emit_kind;
			oslot_q <= 4'(slot);
			ohit_q <= 1'b0;
			olast_q <= 1'b0;
			unique case (cmd.emit_kind)
				KIND_WRITE: begin
					osec_q <= {page_q[slot], head_q[2:0]};
					olen_q <= pos_q - head_q;
					ooff_q <= head_q[2:0];
				end
				KIND_READ: begin
					osec_q <= {page, 3'd0};
					olen_q <= 4'd8;
					ooff_q <= '0;
				end
				KIND_GRANT: begin
					osec_q <= addr_q;
					olen_q <= count_q;
					ooff_q <= off;
					ohit_q <= hit_q;
					olast_q <= 1'b1;
				end
				default: begin
					osec_q <= '0;
					olen_q <= '0;
					oslot_q <= '0;
					ooff_q <= '0;
					olast_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_kind = okind_q;
	assign out_last = olast_q;
	assign out_data = {4'd0, ohit_q, ooff_q, oslot_q, olen_q, osec_q};

endmodule

// File: sv/sector_page_cache_controller_core.sv
// sector page cache controller: fully associative write-back page cache
// a bad request ends in a bad result; otherwise the slots are scanned (up to 16,
// ending on a hit), then a write miss, or a read that misses or hits a partly
// valid page, walks the slot's dirty mask over 9 positions for write-backs, a read
// then reads the page, and a grant result ends the request; one request at a
// time; reset clears every slot, the request counter and the output valid flag
module sector_page_cache_controller_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [55:0] s_tdata, // sector_addr[47:0], sector_count[51:48], zero
	input  logic s_tuser,        // func
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata, // disk_sector, run_length, slot_index, sector_offset, hit, zero
	output logic [1:0] m_tuser,  // kind
	output logic m_tlast
);
	import spcc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	spcc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(s_tdata[51:0]),
		.in_func(s_tuser), .cmd(cmd), .sts(sts), .out_valid(m_tvalid),
		.out_ready(m_tready), .out_data(m_tdata), .out_kind(m_tuser), .out_last(m_tlast)
	);

endmodule
